/* sv/u8sd_pkg.sv */
package u8sd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned USED_W   = 3;
    localparam int unsigned PEND_W   = 2;
    // code_point + status + bytes_used, padded to whole bytes
    localparam int unsigned M_DATA_W = 32;
    localparam int unsigned S_DATA_W = 8;

    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        logic [USED_W-1:0] bytes_used;
        status_t           status;
        logic [CP_W-1:0]   code_point;
    } result_t;

endpackage

/* sv/utf8_stream_decoder_unit.sv */
// Channel  | Ports                              | Payload (lowest bit up)
// ---------+------------------------------------+------------------------------------------
// input    | s_tvalid s_tready s_tdata s_tlast  | tdata[7:0] in_byte; tlast end_of_string
// result   | m_tvalid m_tready m_tdata          | tdata[20:0] code_point, [22:21] status,
//          |                                    | [25:23] bytes_used, [31:26] zero
//
// One byte per cycle sustained, unless a stalled result holds back a byte that would produce a result. A
// byte is held in the input register, the decode logic updates the sequence state and loads the result
// register: a result shows on m_tdata once its last byte has passed the input register and the decode logic.
// Reset (aresetn low at a clock edge) empties both registers and closes any open
// sequence. A stalled result only holds back bytes that would produce a result;
// bytes inside an open sequence keep flowing through.
module utf8_stream_decoder_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u8sd_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] in_byte
    input  logic                               s_tlast,   // end_of_string
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u8sd_pkg::M_DATA_W-1:0]      m_tdata    // code_point, status, bytes_used
);
    import u8sd_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // sequence state
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [CP_W-1:0]   acc_reg, acc_next;
    logic [USED_W-1:0] cons_reg, cons_next;

    // result register
    logic              out_valid_reg;
    result_t           out_reg;

    result_t           res;
    logic              emit;
    logic              out_free;
    logic              advance;
    logic [CP_W-1:0]   acc_shift;
    logic [USED_W-1:0] cons_inc;
    logic [PEND_W-1:0] pend_dec;

    assign out_free = !out_valid_reg || m_tready;
    // a byte leaves the input register unless its result has nowhere to go
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign acc_shift = {acc_reg[CP_W-7:0], in_byte_reg[5:0]};
    assign cons_inc  = cons_reg + USED_W'(1);
    assign pend_dec  = pending_reg - PEND_W'(1);

    always_comb begin
        emit           = 1'b0;
        res.code_point = '0;
        res.status     = ST_VALID;
        res.bytes_used = USED_W'(1);
        pending_next   = '0;
        acc_next       = '0;
        cons_next      = '0;
        if (pending_reg == '0) begin
            case (in_byte_reg) inside
                [8'h00:8'h7F]: begin
                    emit           = 1'b1;
                    res.code_point = CP_W'(in_byte_reg);
                end
                [8'hC2:8'hDF]: begin
                    pending_next = PEND_W'(1);
                    acc_next     = CP_W'(in_byte_reg[4:0]);
                    cons_next    = USED_W'(1);
                end
                [8'hE0:8'hEF]: begin
                    pending_next = PEND_W'(2);
                    acc_next     = CP_W'(in_byte_reg[3:0]);
                    cons_next    = USED_W'(1);
                end
                [8'hF0:8'hF4]: begin
                    pending_next = PEND_W'(3);
                    acc_next     = CP_W'(in_byte_reg[2:0]);
                    cons_next    = USED_W'(1);
                end
                default: begin
                    // stray continuation, overlong 2-byte lead or lead above F4
                    emit       = 1'b1;
                    res.status = ST_INVALID;
                end
            endcase
            // lead byte carrying the end mark: sequence cut short
            if (!emit && in_last_reg) begin
                emit         = 1'b1;
                res.status   = ST_TRUNC;
                pending_next = '0;
                acc_next     = '0;
                cons_next    = '0;
            end
        end else begin
            // continuation payload taken without a tag check
            if (pend_dec == '0) begin
                emit           = 1'b1;
                res.bytes_used = cons_inc;
                if (cons_inc == USED_W'(4) && acc_shift > CP_MAX) begin
                    res.status = ST_RANGE;
                end else begin
                    res.code_point = acc_shift;
                end
            end else if (in_last_reg) begin
                emit           = 1'b1;
                res.status     = ST_TRUNC;
                res.bytes_used = cons_inc;
            end else begin
                pending_next = pend_dec;
                acc_next     = acc_shift;
                cons_next    = cons_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            acc_reg       <= '0;
            cons_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                pending_reg <= pending_next;
                acc_reg     <= acc_next;
                cons_reg    <= cons_next;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (advance && emit) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_reg);

endmodule

/* sv/u8sd_checker.sv */
module u8sd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [u8sd_pkg::M_DATA_W-1:0] m_tdata
);
    import u8sd_pkg::*;

    result_t r;
    assign r = result_t'(m_tdata[CP_W+STATUS_W+USED_W-1:0]);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> r.bytes_used != '0 && r.bytes_used <= USED_W'(4))
        else $error("bytes_used out of 1..4");

    a_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.status == ST_INVALID |-> r.bytes_used == USED_W'(1)
            && r.code_point == '0)
        else $error("invalid lead result malformed");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.status == ST_RANGE |-> r.bytes_used == USED_W'(4)
            && r.code_point == '0)
        else $error("out-of-range result malformed");

    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.status == ST_VALID && r.bytes_used == USED_W'(1)
            |-> r.code_point < CP_W'(8'h80))
        else $error("single-byte code point above 7F");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_u8sd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
